// ===== src/pfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_pkg
// Types, constants and lookup functions shared by the Playfair digraph
// encryptor modules.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int SQ_SIZE   = 5;
    localparam int CODE_W    = 5;
    localparam int ROW_W     = SQ_SIZE * CODE_W;
    localparam int POS_W     = 3;
    localparam int CFG_IDX_W = 3;

    typedef logic [CODE_W-1:0]    letter_t;
    typedef logic [ROW_W-1:0]     key_row_t;
    typedef key_row_t [SQ_SIZE-1:0] key_square_t;
    typedef logic [POS_W-1:0]     pos_t;

    localparam letter_t LETTER_I = letter_t'(8);
    localparam letter_t LETTER_J = letter_t'(9);
    localparam letter_t LETTER_X = letter_t'(23);

    localparam pos_t POS_FIRST = pos_t'(0);
    localparam pos_t POS_LAST  = pos_t'(SQ_SIZE - 1);

    // Square after reset, rows LGDBA / QMHEC / URNIF / XVSOK / ZYWTP
    localparam key_row_t KEY_ROW_ZERO_RST  = key_row_t'(36043);
    localparam key_row_t KEY_ROW_ONE_RST   = key_row_t'(2235792);
    localparam key_row_t KEY_ROW_TWO_RST   = key_row_t'(5518900);
    localparam key_row_t KEY_ROW_THREE_RST = key_row_t'(10963639);
    localparam key_row_t KEY_ROW_FOUR_RST  = key_row_t'(16374553);

    typedef enum logic [CFG_IDX_W-1:0] {
        KEY_ROW_ZERO  = 3'd0,
        KEY_ROW_ONE   = 3'd1,
        KEY_ROW_TWO   = 3'd2,
        KEY_ROW_THREE = 3'd3,
        KEY_ROW_FOUR  = 3'd4
    } cfg_idx_t;

    // One digraph on its way to the cipher stage; dup asks for a second
    // copy with the last flag set.
    typedef struct packed {
        letter_t first;
        letter_t second;
        logic    last;
        logic    dup;
    } pair_t;

    typedef struct packed {
        pos_t row;
        pos_t col;
    } loc_t;

    function automatic letter_t key_cell(input key_square_t sq, input pos_t r, input pos_t c);
        key_row_t row;
        letter_t  code;
        row = sq[r];
        case (c)
            3'd0:    code = row[4:0];
            3'd1:    code = row[9:5];
            3'd2:    code = row[14:10];
            3'd3:    code = row[19:15];
            3'd4:    code = row[24:20];
            default: code = row[4:0];
        endcase
        return code;
    endfunction

    // Priority search: the lowest row-major match wins, no match gives 0,0.
    function automatic loc_t locate(input key_square_t sq, input letter_t letter);
        loc_t loc;
        loc.row = POS_FIRST;
        loc.col = POS_FIRST;
        for (int i = SQ_SIZE - 1; i >= 0; i--)
        begin
            for (int j = SQ_SIZE - 1; j >= 0; j--)
            begin
                if (key_cell(sq, pos_t'(i), pos_t'(j)) == letter)
                begin
                    loc.row = pos_t'(i);
                    loc.col = pos_t'(j);
                end
            end
        end
        return loc;
    endfunction

    function automatic pos_t wrap_inc(input pos_t p);
        return (p == POS_LAST) ? POS_FIRST : pos_t'(p + pos_t'(1));
    endfunction

endpackage
`default_nettype wire

// ===== src/playfair_digraph_encrypt_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt_core
// Playfair encryptor: letter stream in, cipher digraph stream out.
// ----------------------------------------------------------------------------
// Accepts one plaintext letter (A=0..Z=25, J folded to I) per clock on the
// slave stream unless the output side stalls, tlast marking the end of the
// message. Letters pair up into digraphs; a doubled letter is split with X,
// a lone final letter is padded with X. Each digraph leaves on the master
// stream as one request: it is registered in the pair register, then goes
// through the 25-way key square search into the output register. A doubled
// letter at the end of a message yields two requests, which holds the output
// register, and so the input, until the second is taken. The key square
// is five 25-bit rows written at config indices 0..4; write only while idle.
// ----------------------------------------------------------------------------
module playfair_digraph_encrypt_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [pfd_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [pfd_pkg::ROW_W-1:0]     cfg_wdata,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // [4:0] plain_letter
    input  wire logic                          s_axis_tlast,  // end_of_message
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // [4:0] cipher_first,
                                                              // [9:5] cipher_second
    output logic                               m_axis_tlast   // last_pair
);

    pfd_pkg::key_square_t square;
    pfd_pkg::pair_t       pair;
    logic                 pair_valid;
    logic                 pair_ready;
    pfd_pkg::letter_t     cipher_first;
    pfd_pkg::letter_t     cipher_second;

    pfd_keysq u_keysq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .square    (square)
    );

    pfd_pair u_pair
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_letter  (s_axis_tdata[4:0]),
        .in_last    (s_axis_tlast),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair)
    );

    pfd_cipher u_cipher
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .square     (square),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_first  (cipher_first),
        .out_second (cipher_second),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, cipher_second, cipher_first};

endmodule
`default_nettype wire

// ===== src/pfd_keysq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_keysq
// Key square register file, written row by row from the config port.
// ----------------------------------------------------------------------------
module pfd_keysq
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pfd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [pfd_pkg::ROW_W-1:0]         cfg_wdata,
    output pfd_pkg::key_square_t                   square
);

    pfd_pkg::key_square_t square_reg;
    pfd_pkg::key_square_t square_next;

    always_comb
    begin
        square_next = square_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                pfd_pkg::KEY_ROW_ZERO:  square_next[0] = cfg_wdata;
                pfd_pkg::KEY_ROW_ONE:   square_next[1] = cfg_wdata;
                pfd_pkg::KEY_ROW_TWO:   square_next[2] = cfg_wdata;
                pfd_pkg::KEY_ROW_THREE: square_next[3] = cfg_wdata;
                pfd_pkg::KEY_ROW_FOUR:  square_next[4] = cfg_wdata;
                default:                square_next = square_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg[0] <= pfd_pkg::KEY_ROW_ZERO_RST;
            square_reg[1] <= pfd_pkg::KEY_ROW_ONE_RST;
            square_reg[2] <= pfd_pkg::KEY_ROW_TWO_RST;
            square_reg[3] <= pfd_pkg::KEY_ROW_THREE_RST;
            square_reg[4] <= pfd_pkg::KEY_ROW_FOUR_RST;
        end
        else
        begin
            square_reg <= square_next;
        end
    end

    assign square = square_reg;

endmodule
`default_nettype wire

// ===== src/pfd_pair.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_pair
// Digraph former: holds the pending letter, splits doubled letters and pads
// a lone final letter with X, then registers the pair.
// ----------------------------------------------------------------------------
module pfd_pair
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pfd_pkg::letter_t   in_letter,
    input  wire logic               in_last,
    output logic                    pair_valid,
    input  wire logic               pair_ready,
    output pfd_pkg::pair_t          pair
);

    pfd_pkg::letter_t pend_letter_reg;
    pfd_pkg::letter_t pend_letter_next;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    logic             pair_valid_reg;
    logic             pair_valid_next;
    pfd_pkg::pair_t   pair_reg;
    pfd_pkg::pair_t   pair_next;

    pfd_pkg::letter_t letter;
    logic             accept;
    logic             emit;

    assign in_ready = !pair_valid_reg || pair_ready;
    assign accept   = in_valid && in_ready;
    assign letter   = (in_letter == pfd_pkg::LETTER_J) ? pfd_pkg::LETTER_I : in_letter;

    always_comb
    begin
        pend_letter_next = pend_letter_reg;
        pend_valid_next  = pend_valid_reg;
        pair_next        = pair_reg;
        emit             = 1'b0;
        if (accept)
        begin
            if (!pend_valid_reg)
            begin
                if (in_last)
                begin
                    emit      = 1'b1;
                    pair_next = '{first: letter, second: pfd_pkg::LETTER_X,
                                  last: 1'b1, dup: 1'b0};
                end
                else
                begin
                    pend_letter_next = letter;
                    pend_valid_next  = 1'b1;
                end
            end
            else if (pend_letter_reg != letter)
            begin
                emit            = 1'b1;
                pair_next       = '{first: pend_letter_reg, second: letter,
                                    last: in_last, dup: 1'b0};
                pend_valid_next = 1'b0;
            end
            else
            begin
                // doubled letter: pad with X, keep the letter pending unless
                // the message ends, then the same pair goes out twice
                emit            = 1'b1;
                pair_next       = '{first: pend_letter_reg, second: pfd_pkg::LETTER_X,
                                    last: 1'b0, dup: in_last};
                pend_valid_next = !in_last;
            end
        end
        pair_valid_next = (pair_valid_reg && !pair_ready) || emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_letter_reg <= '0;
            pend_valid_reg  <= 1'b0;
            pair_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_letter_reg <= pend_letter_next;
            pend_valid_reg  <= pend_valid_next;
            pair_valid_reg  <= pair_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
    end

    assign pair_valid = pair_valid_reg;
    assign pair       = pair_reg;

endmodule
`default_nettype wire

// ===== src/pfd_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_cipher
// Locates both letters of a digraph in the key square, applies the row,
// column or rectangle rule and registers the cipher pair for output.
// ----------------------------------------------------------------------------
module pfd_cipher
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pfd_pkg::key_square_t  square,
    input  wire logic                  pair_valid,
    output logic                       pair_ready,
    input  wire pfd_pkg::pair_t        pair,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output pfd_pkg::letter_t           out_first,
    output pfd_pkg::letter_t           out_second,
    output logic                       out_last
);

    pfd_pkg::loc_t    loc_a;
    pfd_pkg::loc_t    loc_b;
    pfd_pkg::letter_t enc_a;
    pfd_pkg::letter_t enc_b;

    logic             valid_reg;
    logic             valid_next;
    logic             rep_reg;
    logic             rep_next;
    logic             last_reg;
    logic             last_next;
    pfd_pkg::letter_t first_reg;
    pfd_pkg::letter_t first_next;
    pfd_pkg::letter_t second_reg;
    pfd_pkg::letter_t second_next;

    logic             take;
    logic             drain;

    always_comb
    begin
        loc_a = pfd_pkg::locate(square, pair.first);
        loc_b = pfd_pkg::locate(square, pair.second);
        if (loc_a.row == loc_b.row)
        begin
            enc_a = pfd_pkg::key_cell(square, loc_a.row, pfd_pkg::wrap_inc(loc_a.col));
            enc_b = pfd_pkg::key_cell(square, loc_b.row, pfd_pkg::wrap_inc(loc_b.col));
        end
        else if (loc_a.col == loc_b.col)
        begin
            enc_a = pfd_pkg::key_cell(square, pfd_pkg::wrap_inc(loc_a.row), loc_a.col);
            enc_b = pfd_pkg::key_cell(square, pfd_pkg::wrap_inc(loc_b.row), loc_b.col);
        end
        else
        begin
            enc_a = pfd_pkg::key_cell(square, loc_a.row, loc_b.col);
            enc_b = pfd_pkg::key_cell(square, loc_b.row, loc_a.col);
        end
    end

    // output register frees only when its last copy is taken
    assign drain      = valid_reg && out_ready;
    assign pair_ready = !valid_reg || (out_ready && !rep_reg);
    assign take       = pair_valid && pair_ready;

    always_comb
    begin
        valid_next  = valid_reg;
        rep_next    = rep_reg;
        last_next   = last_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (take)
        begin
            valid_next  = 1'b1;
            rep_next    = pair.dup;
            last_next   = pair.last;
            first_next  = enc_a;
            second_next = enc_b;
        end
        else if (drain)
        begin
            if (rep_reg)
            begin
                // resend the same pair, now marked last
                rep_next  = 1'b0;
                last_next = 1'b1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rep_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rep_reg   <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg   <= last_next;
        first_reg  <= first_next;
        second_reg <= second_next;
    end

    assign out_valid  = valid_reg;
    assign out_first  = first_reg;
    assign out_second = second_reg;
    assign out_last   = last_reg;

endmodule
`default_nettype wire
